// ----- rtl/cfr_pkg.sv -----
// Shared types, widths and helpers for the path curve flattener.
`default_nettype none
package cfr_pkg;

   localparam int COORD_W = 24;   // signed 16.8 coordinate
   localparam int RES_W   = 6;    // curve resolution register
   localparam int COEF_W  = 30;   // per-axis polynomial coefficient
   localparam int WGT_W   = 18;   // polynomial weight in i, d, r
   localparam int DEN_W   = 19;   // curve denominator
   localparam int ACC_W   = 52;   // weighted sum of coefficients
   localparam int DIV_W   = 54;   // dividend of the rounding divide
   localparam int DVS_W   = DEN_W + 1;
   localparam int SUM_W   = DIV_W + 2;
   localparam int DIV_CNT_W = $clog2(DIV_W + 1);   // divider step counter

   localparam logic [RES_W-1:0] RES_RESET = RES_W'(20);
   localparam logic [RES_W-1:0] RES_MIN   = RES_W'(2);

   // register indexes of the configuration port
   localparam logic REG_RESOLUTION = 1'b0;

   typedef enum logic [2:0] {
      OP_ADD_VERTEX  = 3'd0,
      OP_CUBIC       = 3'd1,
      OP_QUADRATIC   = 3'd2,
      OP_CATMULL     = 3'd3,
      OP_NEW_SUBPATH = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      MODE_CUBIC   = 2'd0,
      MODE_QUAD    = 2'd1,
      MODE_CATMULL = 2'd2
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'd0,
      ST_PREP   = 3'd1,
      ST_WEIGHT = 3'd2,
      ST_MAC    = 3'd3,
      ST_DIVGO  = 3'd4,
      ST_DIV    = 3'd5,
      ST_EMIT   = 3'd6
   } state_type;

   typedef struct packed {
      logic start;
      logic neg;
   } div_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   // clamp a wide signed value to the coordinate range
   function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] hi;
      logic signed [SUM_W-1:0] lo;
      hi = SUM_W'((64'sd1 <<< (COORD_W - 1)) - 64'sd1);
      lo = -hi - SUM_W'(1);
      if (v > hi) begin
         sat_coord = hi[COORD_W-1:0];
      end else if (v < lo) begin
         sat_coord = lo[COORD_W-1:0];
      end else begin
         sat_coord = v[COORD_W-1:0];
      end
   endfunction

endpackage
`default_nettype wire

// ----- rtl/cfr_if.sv -----
// Valid/ready channel interfaces for path commands and emitted vertices.
`default_nettype none
interface cfr_req_if import cfr_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [2:0]                operation;
   logic signed [COORD_W-1:0] first_x;
   logic signed [COORD_W-1:0] first_y;
   logic signed [COORD_W-1:0] first_z;
   logic signed [COORD_W-1:0] second_x;
   logic signed [COORD_W-1:0] second_y;
   logic signed [COORD_W-1:0] second_z;
   logic signed [COORD_W-1:0] third_x;
   logic signed [COORD_W-1:0] third_y;
   logic signed [COORD_W-1:0] third_z;

   modport source (output valid, operation, first_x, first_y, first_z, second_x, second_y,
                   second_z, third_x, third_y, third_z, input ready);
   modport sink (input valid, operation, first_x, first_y, first_z, second_x, second_y,
                 second_z, third_x, third_y, third_z, output ready);
endinterface

interface cfr_rsp_if import cfr_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [COORD_W-1:0] out_x;
   logic signed [COORD_W-1:0] out_y;
   logic signed [COORD_W-1:0] out_z;
   logic                      last_of_run;

   modport source (output valid, out_x, out_y, out_z, last_of_run, input ready);
   modport sink (input valid, out_x, out_y, out_z, last_of_run, output ready);
endinterface
`default_nettype wire

// ----- rtl/cfr_csr.sv -----
// APB-style register file holding the curve resolution.
`default_nettype none
module cfr_csr import cfr_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             psel,
   input  wire logic             penable,
   input  wire logic             pwrite,
   input  wire logic [2:0]       paddr,
   input  wire logic [31:0]      pwdata,
   output logic [31:0]           prdata,
   output logic                  pready,
   output logic [RES_W-1:0]      resolution
);
   logic [RES_W-1:0] res_ff;
   logic [RES_W-1:0] res_in;
   logic             wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite & (paddr[2] == REG_RESOLUTION);

   // update on a completed write transaction
   always_comb begin
      res_in = res_ff;
      if (wr_en) begin
         res_in = pwdata[RES_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_ff <= RES_RESET;
      end else begin
         res_ff <= res_in;
      end
   end

   // read back
   always_comb begin
      prdata = '0;
      if (paddr[2] == REG_RESOLUTION) begin
         prdata = {{(32-RES_W){1'b0}}, res_ff};
      end
   end

   assign resolution = res_ff;
endmodule
`default_nettype wire

// ----- rtl/cfr_divider.sv -----
// Shared restoring divider, one quotient bit per cycle.
`default_nettype none
module cfr_divider import cfr_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire div_ctrl_type          ctrl,
   input  wire logic [DIV_W-1:0]      dividend,
   input  wire logic [DVS_W-1:0]      divisor,
   output div_stat_type               stat,
   output logic signed [DIV_W:0]      quotient
);
   logic [DIV_W-1:0]     work_ff, work_in;
   logic [DVS_W-1:0]     rem_ff, rem_in;
   logic [DVS_W-1:0]     dvs_ff, dvs_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic             neg_ff, neg_in;
   logic [DVS_W:0]   trial;
   logic [DVS_W:0]   diff;

   assign trial = {rem_ff, work_ff[DIV_W-1]};
   assign diff  = trial - {1'b0, dvs_ff};

   // shift one dividend bit into the remainder and decide one quotient bit
   always_comb begin
      work_in = work_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      neg_in  = neg_ff;
      done_in = 1'b0;
      if (ctrl.start) begin
         work_in = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         neg_in  = ctrl.neg;
         cnt_in  = DIV_CNT_W'(DIV_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in  = diff[DVS_W-1:0];
            work_in = {work_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in  = trial[DVS_W-1:0];
            work_in = {work_ff[DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      work_ff <= work_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      neg_ff  <= neg_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = neg_ff ? -$signed({1'b0, work_ff}) : $signed({1'b0, work_ff});
endmodule
`default_nettype wire

// ----- rtl/path_curve_flattener_core.sv -----
// Top level of the path curve flattener: sequencer, coefficient datapath and output register.
`default_nettype none
// Turns path commands into 3-D vertices in signed 16.8, saturated. Add vertex emits one vertex
// through the emit state and the output register. A curve emits max(resolution, 2) points
// (quadratic: one more); the three axes of each point share one multiply-accumulate step and
// one bit-serial divider that produces the rounded quotient at one bit per cycle.
// req_port.ready is high only while no command is in work. Catmull-Rom points that only fill
// the window, new subpath, cubic without a last point and unused codes emit nothing and leave
// the block idle.
module path_curve_flattener_core import cfr_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   cfr_req_if.sink            req_port,
   cfr_rsp_if.source          rsp_port,
   input  wire logic          psel,
   input  wire logic          penable,
   input  wire logic          pwrite,
   input  wire logic [2:0]    paddr,
   input  wire logic [31:0]   pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);
   logic [RES_W-1:0] resolution;
   logic [RES_W-1:0] r_eff;
   logic [RES_W-1:0] d_eff;

   state_type state_ff, state_in;
   mode_type  mode_ff, mode_in;
   logic [RES_W-1:0] idx_ff, idx_in;
   logic [RES_W-1:0] last_ff, last_in;
   logic [1:0] axis_ff, axis_in;
   logic [1:0] term_ff, term_in;
   logic signed [COEF_W-1:0] coef_ff [3][4];
   logic signed [COEF_W-1:0] coef_in [3][4];
   logic signed [COORD_W-1:0] base_ff [3];
   logic signed [COORD_W-1:0] base_in [3];
   logic [11:0] sq_ff, sq_in, dd_ff, dd_in;
   logic [RES_W-1:0] rmi_ff, rmi_in;
   logic [WGT_W-1:0] w_ff [4];
   logic [WGT_W-1:0] w_in [4];
   logic [DEN_W-1:0] den_ff, den_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic signed [COORD_W-1:0] pt_ff [3];
   logic signed [COORD_W-1:0] pt_in [3];
   logic prev_valid_ff, prev_valid_in;
   logic signed [COORD_W-1:0] prev_ff [3];
   logic signed [COORD_W-1:0] prev_in [3];
   logic signed [COORD_W-1:0] win_ff [3][3];
   logic signed [COORD_W-1:0] win_in [3][3];
   logic [1:0] fill_ff, fill_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic signed [COORD_W-1:0] rsp_pt_ff [3];
   logic signed [COORD_W-1:0] rsp_pt_in [3];
   logic rsp_last_ff, rsp_last_in;

   logic accept;
   logic slot_free;
   logic emit_go;
   logic mac_en;
   div_ctrl_type div_ctrl;
   div_stat_type div_stat;
   logic [DIV_W-1:0] div_dividend;
   logic [DVS_W-1:0] div_divisor;
   logic signed [DIV_W:0] div_quo;
   logic signed [DIV_W-1:0] num_n;
   logic signed [COEF_W+WGT_W:0] prod;
   logic signed [SUM_W-1:0] pt_sum;
   op_type req_op;
   logic signed [COORD_W-1:0] req_a [3];
   logic signed [COORD_W-1:0] req_b [3];
   logic signed [COORD_W-1:0] req_c [3];

   cfr_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .resolution (resolution)
   );

   assign r_eff = (resolution < RES_MIN) ? RES_MIN : resolution;
   assign d_eff = r_eff - RES_W'(1);

   assign req_op   = op_type'(req_port.operation);
   assign req_a[0] = req_port.first_x;
   assign req_a[1] = req_port.first_y;
   assign req_a[2] = req_port.first_z;
   assign req_b[0] = req_port.second_x;
   assign req_b[1] = req_port.second_y;
   assign req_b[2] = req_port.second_z;
   assign req_c[0] = req_port.third_x;
   assign req_c[1] = req_port.third_y;
   assign req_c[2] = req_port.third_z;

   assign req_port.ready = (state_ff == ST_IDLE);
   assign accept         = req_port.valid & req_port.ready;
   assign slot_free      = ~rsp_valid_ff | rsp_port.ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_op)
                  OP_ADD_VERTEX: state_in = ST_EMIT;
                  OP_CUBIC:      state_in = prev_valid_ff ? ST_PREP : ST_IDLE;
                  OP_QUADRATIC:  state_in = ST_PREP;
                  OP_CATMULL:    state_in = (fill_ff == 2'd3) ? ST_PREP : ST_IDLE;
                  default:       state_in = ST_IDLE;
               endcase
            end
         end
         ST_PREP:   state_in = ST_WEIGHT;
         ST_WEIGHT: state_in = ST_MAC;
         ST_MAC:    state_in = (term_ff == 2'd3) ? ST_DIVGO : ST_MAC;
         ST_DIVGO:  state_in = ST_DIV;
         ST_DIV: begin
            if (div_stat.done) begin
               state_in = (axis_ff == 2'd2) ? ST_EMIT : ST_MAC;
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               state_in = (idx_ff == last_ff) ? ST_IDLE : ST_PREP;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // per-state controls
   always_comb begin
      mac_en        = 1'b0;
      div_ctrl      = '0;
      emit_go       = 1'b0;
      unique case (state_ff)
         ST_MAC:   mac_en = 1'b1;
         ST_DIVGO: div_ctrl.start = 1'b1;
         ST_EMIT:  emit_go = slot_free;
         default:  ;
      endcase
      div_ctrl.neg = num_n < 0;
   end

   // rounded divide: floor((2*num + den) / (2*den)) on magnitudes
   assign num_n = DIV_W'(acc_ff <<< 1) + $signed({{(DIV_W-DEN_W){1'b0}}, den_ff});
   assign div_divisor = {den_ff, 1'b0};
   assign div_dividend = (num_n < 0)
      ? DIV_W'(-num_n + $signed({{(DIV_W-DVS_W){1'b0}}, div_divisor}) - DIV_W'(1))
      : DIV_W'(num_n);

   cfr_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (div_ctrl),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .stat     (div_stat),
      .quotient (div_quo)
   );

   assign prod   = coef_ff[axis_ff][term_ff] * $signed({1'b0, w_ff[term_ff]});
   assign pt_sum = SUM_W'(base_ff[axis_ff]) + SUM_W'(div_quo);

   // datapath updates
   always_comb begin
      logic signed [COEF_W-1:0] a, b, c, x0, cc, cb, p0, p1, p2;
      a  = '0;  b  = '0;  c  = '0;
      x0 = '0;  cc = '0;  cb = '0;
      p0 = '0;  p1 = '0;  p2 = '0;
      mode_in       = mode_ff;
      idx_in        = idx_ff;
      last_in       = last_ff;
      axis_in       = axis_ff;
      term_in       = term_ff;
      coef_in       = coef_ff;
      base_in       = base_ff;
      sq_in         = sq_ff;
      dd_in         = dd_ff;
      rmi_in        = rmi_ff;
      w_in          = w_ff;
      den_in        = den_ff;
      acc_in        = acc_ff;
      pt_in         = pt_ff;
      prev_valid_in = prev_valid_ff;
      prev_in       = prev_ff;
      win_in        = win_ff;
      fill_in       = fill_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_port.ready;
      rsp_pt_in     = rsp_pt_ff;
      rsp_last_in   = rsp_last_ff;

      // take a command: build coefficients and update window state
      if (accept) begin
         idx_in = '0;
         unique case (req_op)
            OP_ADD_VERTEX: begin
               fill_in = '0;
               pt_in   = req_c;
               last_in = '0;
            end
            OP_CUBIC: begin
               fill_in = '0;
               mode_in = MODE_CUBIC;
               last_in = d_eff;
               for (int j = 0; j < 3; j++) begin
                  a  = COEF_W'(req_a[j]);
                  b  = COEF_W'(req_b[j]);
                  c  = COEF_W'(req_c[j]);
                  x0 = COEF_W'(prev_ff[j]);
                  cc = COEF_W'(3) * (a - x0);
                  cb = COEF_W'(3) * (b - a) - cc;
                  coef_in[j][0] = '0;
                  coef_in[j][1] = cc;
                  coef_in[j][2] = cb;
                  coef_in[j][3] = c - x0 - cc - cb;
                  base_in[j]    = prev_ff[j];
               end
            end
            OP_QUADRATIC: begin
               fill_in = '0;
               mode_in = MODE_QUAD;
               last_in = r_eff;
               for (int j = 0; j < 3; j++) begin
                  coef_in[j][0] = '0;
                  coef_in[j][1] = COEF_W'(req_a[j]);
                  coef_in[j][2] = COEF_W'(req_b[j]);
                  coef_in[j][3] = COEF_W'(req_c[j]);
                  base_in[j]    = '0;
               end
            end
            OP_CATMULL: begin
               mode_in = MODE_CATMULL;
               last_in = d_eff;
               if (fill_ff != 2'd3) begin
                  win_in[fill_ff] = req_c;
                  fill_in         = fill_ff + 2'd1;
               end else begin
                  for (int j = 0; j < 3; j++) begin
                     p0 = COEF_W'(win_ff[0][j]);
                     p1 = COEF_W'(win_ff[1][j]);
                     p2 = COEF_W'(win_ff[2][j]);
                     c  = COEF_W'(req_c[j]);
                     coef_in[j][0] = p1 <<< 1;
                     coef_in[j][1] = p2 - p0;
                     coef_in[j][2] = (p0 <<< 1) - COEF_W'(5) * p1 + (p2 <<< 2) - c;
                     coef_in[j][3] = -p0 + COEF_W'(3) * p1 - COEF_W'(3) * p2 + c;
                     base_in[j]    = '0;
                  end
                  // drop the oldest point
                  win_in[0] = win_ff[1];
                  win_in[1] = win_ff[2];
                  win_in[2] = req_c;
               end
            end
            OP_NEW_SUBPATH: begin
               fill_in       = '0;
               prev_valid_in = 1'b0;
            end
            default: ;
         endcase
      end

      // small terms of the sample index and the resolution
      if (state_ff == ST_PREP) begin
         sq_in  = idx_ff * idx_ff;
         dd_in  = d_eff * d_eff;
         rmi_in = r_eff - idx_ff;
      end

      // polynomial weights and denominator
      if (state_ff == ST_WEIGHT) begin
         axis_in = '0;
         term_in = '0;
         acc_in  = '0;
         if (mode_ff == MODE_QUAD) begin
            w_in[0] = '0;
            w_in[1] = WGT_W'(rmi_ff * rmi_ff);
            w_in[2] = WGT_W'(idx_ff * rmi_ff) << 1;
            w_in[3] = WGT_W'(sq_ff);
            den_in  = DEN_W'(r_eff * r_eff);
         end else begin
            w_in[0] = WGT_W'(dd_ff * d_eff);
            w_in[1] = WGT_W'(idx_ff * dd_ff);
            w_in[2] = WGT_W'(sq_ff * d_eff);
            w_in[3] = WGT_W'(sq_ff * idx_ff);
            if (mode_ff == MODE_CATMULL) begin
               den_in = DEN_W'(dd_ff * d_eff) << 1;
            end else begin
               den_in = DEN_W'(dd_ff * d_eff);
            end
         end
      end

      // accumulate one weighted coefficient
      if (mac_en) begin
         acc_in  = acc_ff + ACC_W'(prod);
         term_in = term_ff + 2'd1;
      end

      // store one finished axis
      if (state_ff == ST_DIV && div_stat.done) begin
         pt_in[axis_ff] = sat_coord(pt_sum);
         axis_in        = axis_ff + 2'd1;
         term_in        = '0;
         acc_in         = '0;
      end

      // hand the vertex to the output register
      if (emit_go) begin
         rsp_valid_in  = 1'b1;
         rsp_pt_in     = pt_ff;
         rsp_last_in   = (idx_ff == last_ff);
         prev_in       = pt_ff;
         prev_valid_in = 1'b1;
         idx_in        = idx_ff + RES_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         prev_valid_ff <= 1'b0;
         fill_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
         for (int j = 0; j < 3; j++) begin
            prev_ff[j] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         prev_valid_ff <= prev_valid_in;
         fill_ff       <= fill_in;
         rsp_valid_ff  <= rsp_valid_in;
         prev_ff       <= prev_in;
      end
      mode_ff     <= mode_in;
      idx_ff      <= idx_in;
      last_ff     <= last_in;
      axis_ff     <= axis_in;
      term_ff     <= term_in;
      coef_ff     <= coef_in;
      base_ff     <= base_in;
      sq_ff       <= sq_in;
      dd_ff       <= dd_in;
      rmi_ff      <= rmi_in;
      w_ff        <= w_in;
      den_ff      <= den_in;
      acc_ff      <= acc_in;
      pt_ff       <= pt_in;
      win_ff      <= win_in;
      rsp_pt_ff   <= rsp_pt_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_port.valid       = rsp_valid_ff;
   assign rsp_port.out_x       = rsp_pt_ff[0];
   assign rsp_port.out_y       = rsp_pt_ff[1];
   assign rsp_port.out_z       = rsp_pt_ff[2];
   assign rsp_port.last_of_run = rsp_last_ff;

   // the divider only runs while the sequencer waits for it
   a_div_owner: assert property (@(posedge clock) disable iff (reset)
      div_stat.busy |-> (state_ff == ST_DIV))
      else $error("divider busy outside divide state");

   // the closing vertex of a command returns the block to idle
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (emit_go && idx_ff == last_ff) |=> (state_ff == ST_IDLE))
      else $error("final vertex did not end the command");

   // a vertex is only loaded when the output register can take it
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      emit_go |-> (!rsp_valid_ff || rsp_port.ready))
      else $error("output register overrun");

   // the sample index never passes the last sample
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MAC) |-> (idx_ff <= last_ff))
      else $error("sample index out of range");
endmodule
`default_nettype wire
